/* hw/rtl/zt_pkg.sv */
// Shared constants and fixed-point helpers for the zone tangent frame block.
`timescale 1ns / 1ps
package zt_pkg;
	localparam int FRAC_BITS = 16;
	localparam int FW = 18;
	localparam int ACC_W = 50;
	localparam int PROD_W = 48;
	localparam int OP_W = 24;
	localparam int DIV_NW = 40;
	localparam int DIV_DW = 20;
	localparam int SQ_W = 40;
	localparam int SQ_RW = 20;
	localparam logic [FW-1:0] SCALE_SAT = {FW{1'b1}};

	function automatic logic signed [ACC_W-1:0] shr_round(input logic signed [ACC_W-1:0] p);
		logic [ACC_W-1:0] half;
		logic [ACC_W-1:0] m;
		logic signed [ACC_W-1:0] r;
		half = ACC_W'(1) << (FRAC_BITS - 1);
		if (!p[ACC_W-1]) begin
			m = ($unsigned(p) + half) >> FRAC_BITS;
			r = $signed(m);
		end else begin
			m = ($unsigned(-p) + half) >> FRAC_BITS;
			r = -$signed(m);
		end
		return r;
	endfunction

	function automatic logic signed [FW-1:0] sat18(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'((1 << (FW - 1)) - 1);
		lo = -ACC_W'(1 << (FW - 1));
		if (v > hi) return {1'b0, {(FW-1){1'b1}}};
		else if (v < lo) return {1'b1, {(FW-1){1'b0}}};
		else return v[FW-1:0];
	endfunction
endpackage

/* hw/rtl/zt_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module zt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [zt_pkg::DIV_NW-1:0]   num,
	input  logic [zt_pkg::DIV_DW-1:0]   den,
	output logic                        done,
	output logic [zt_pkg::DIV_NW-1:0]   quo
);
	localparam int CW = $clog2(zt_pkg::DIV_NW);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [zt_pkg::DIV_NW-1:0]   num_q;
	logic [zt_pkg::DIV_DW-1:0]   rem_q;
	logic [zt_pkg::DIV_DW-1:0]   den_q;
	logic [zt_pkg::DIV_DW:0]     remn;
	logic                        qbit;

	always_comb begin
		remn = {rem_q, num_q[zt_pkg::DIV_NW-1]};
		qbit = (remn >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(zt_pkg::DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[zt_pkg::DIV_NW-2:0], qbit};
			rem_q <= qbit ? zt_pkg::DIV_DW'(remn - {1'b0, den_q}) : remn[zt_pkg::DIV_DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;
endmodule

/* hw/rtl/zt_sqrt.sv */
// Digit-by-digit floor square root, one result bit per cycle.
`timescale 1ns / 1ps
module zt_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [zt_pkg::SQ_W-1:0]    val,
	output logic                       done,
	output logic [zt_pkg::SQ_RW-1:0]   root
);
	localparam int CW = $clog2(zt_pkg::SQ_RW);
	localparam int RW = zt_pkg::SQ_RW + 2;

	logic                       busy_q;
	logic                       done_q;
	logic [CW-1:0]              cnt_q;
	logic [zt_pkg::SQ_W-1:0]    val_q;
	logic [RW-1:0]              rem_q;
	logic [zt_pkg::SQ_RW-1:0]   root_q;
	logic [RW+1:0]              remn;
	logic [RW+1:0]              trial;
	logic                       take;

	always_comb begin
		remn  = {rem_q, val_q[zt_pkg::SQ_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		take  = (remn >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(zt_pkg::SQ_RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= val;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[zt_pkg::SQ_W-3:0], 2'b00};
			rem_q  <= take ? RW'(remn - trial) : remn[RW-1:0];
			root_q <= {root_q[zt_pkg::SQ_RW-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

/* hw/rtl/zone_tangent_frame.sv */
// Top level: tangent frame and running position scale of a spherical triangle zone.
`timescale 1ns / 1ps
// One request in, one result out. A small sequencer runs every product through one
// shared 24x24 multiplier, every square root through a 20-step digit-serial unit
// and every quotient through a 40-step bit-serial divider; the twelve divisions
// dominate the work (fewer are run when a radicand is not positive or a length is
// zero). s_tready is high only between items. A finished result sits in an output
// register, so the next request can be taken while it waits.
module zone_tangent_frame (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// zone_index, c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z, zero pad
	input  logic [183:0] s_tdata,
	// restart
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// zone_out, center_x/y/z, axis_a_x/y/z, axis_b_x/y/z, scale_max, zero pad
	output logic [199:0] m_tdata,
	// degenerate
	output logic [0:0]   m_tuser
);
	localparam int FW = zt_pkg::FW;
	localparam int AW = zt_pkg::ACC_W;
	localparam int OW = zt_pkg::OP_W;
	localparam int F  = zt_pkg::FRAC_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAC  = 3'd1;
	localparam logic [2:0] S_POST = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	localparam logic [2:0] J_NC  = 3'd0;
	localparam logic [2:0] J_NA  = 3'd1;
	localparam logic [2:0] J_BX  = 3'd2;
	localparam logic [2:0] J_MU0 = 3'd3;
	localparam logic [2:0] J_MU1 = 3'd4;
	localparam logic [2:0] J_RAD = 3'd5;

	logic [2:0]                  state_q;
	logic [2:0]                  job_q;
	logic [1:0]                  term_q;
	logic [1:0]                  comp_q;
	logic [1:0]                  corner_q;
	logic [15:0]                 zone_q;
	logic signed [FW-1:0]        c_q [9];
	logic signed [19:0]          vec_q [3];
	logic signed [FW-1:0]        ctr_q [3];
	logic signed [FW-1:0]        ax_q [3];
	logic signed [FW-1:0]        bx_q [3];
	logic signed [23:0]          mu0_q;
	logic signed [23:0]          mu1_q;
	logic signed [AW-1:0]        acc_q;
	logic signed [zt_pkg::PROD_W-1:0] prod_q;
	logic [zt_pkg::DIV_DW-1:0]   root_q;
	logic [FW-1:0]               max_q;
	logic                        degen_q;
	logic                        m_tvalid_q;
	logic [199:0]                out_data_q;
	logic                        out_user_q;

	logic                        sq_start_q;
	logic [zt_pkg::SQ_W-1:0]     sq_val_q;
	logic                        sq_done;
	logic [zt_pkg::SQ_RW-1:0]    sq_root;
	logic                        dv_start_q;
	logic [zt_pkg::DIV_NW-1:0]   dv_num_q;
	logic [zt_pkg::DIV_DW-1:0]   dv_den_q;
	logic                        dv_done;
	logic [zt_pkg::DIV_NW-1:0]   dv_quo;

	logic signed [OW-1:0]        mul_a;
	logic signed [OW-1:0]        mul_b;
	logic                        mul_neg;
	logic signed [zt_pkg::PROD_W-1:0] mul_p;
	logic [1:0]                  nterms;
	logic [1:0]                  i1;
	logic [1:0]                  i2;
	logic [3:0]                  cidx;
	logic signed [OW-1:0]        dsel;
	logic [1:0]                  iss_idx;
	logic [zt_pkg::DIV_DW-1:0]   iss_den;
	logic [zt_pkg::DIV_NW-1:0]   iss_num;
	logic [23:0]                 iss_mag;
	logic signed [AW-1:0]        acc_rnd;
	logic                        q_neg;
	logic signed [FW-1:0]        q_norm;
	logic [FW-1:0]               q_scale;
	logic [FW-1:0]               max_upd;

	function automatic logic [1:0] nxt3(input logic [1:0] i);
		case (i)
			2'd0:    return 2'd1;
			2'd1:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic signed [FW-1:0] pick18(input logic signed [FW-1:0] v0,
			input logic signed [FW-1:0] v1, input logic signed [FW-1:0] v2,
			input logic [1:0] i);
		case (i)
			2'd0:    return v0;
			2'd1:    return v1;
			default: return v2;
		endcase
	endfunction

	function automatic logic signed [19:0] pick20(input logic signed [19:0] v0,
			input logic signed [19:0] v1, input logic signed [19:0] v2,
			input logic [1:0] i);
		case (i)
			2'd0:    return v0;
			2'd1:    return v1;
			default: return v2;
		endcase
	endfunction

	zt_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.val    (sq_val_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	zt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start_q),
		.num    (dv_num_q),
		.den    (dv_den_q),
		.done   (dv_done),
		.quo    (dv_quo)
	);

	// multiplier operand select
	always_comb begin
		i1    = nxt3(comp_q);
		i2    = nxt3(i1);
		cidx  = 4'(corner_q) * 4'd3 + 4'(term_q);
		dsel  = OW'(c_q[cidx]) - OW'(pick18(ctr_q[0], ctr_q[1], ctr_q[2], term_q));
		mul_a = '0;
		mul_b = '0;
		mul_neg = 1'b0;
		nterms = 2'd3;
		case (job_q)
			J_NC, J_NA: begin
				mul_a = OW'(pick20(vec_q[0], vec_q[1], vec_q[2], term_q));
				mul_b = mul_a;
			end
			J_BX: begin
				nterms = 2'd2;
				if (term_q == 2'd0) begin
					mul_a = OW'(pick18(ctr_q[0], ctr_q[1], ctr_q[2], i1));
					mul_b = OW'(pick18(ax_q[0], ax_q[1], ax_q[2], i2));
				end else begin
					mul_a = OW'(pick18(ctr_q[0], ctr_q[1], ctr_q[2], i2));
					mul_b = OW'(pick18(ax_q[0], ax_q[1], ax_q[2], i1));
					mul_neg = 1'b1;
				end
			end
			J_MU0: begin
				mul_a = dsel;
				mul_b = OW'(pick18(ax_q[0], ax_q[1], ax_q[2], term_q));
			end
			J_MU1: begin
				mul_a = dsel;
				mul_b = OW'(pick18(bx_q[0], bx_q[1], bx_q[2], term_q));
			end
			J_RAD: begin
				nterms = 2'd2;
				mul_a = (term_q == 2'd0) ? mu0_q : mu1_q;
				mul_b = mul_a;
				mul_neg = 1'b1;
			end
			default: begin
				nterms = 2'd3;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// divider operands and result shaping
	always_comb begin
		iss_idx = (state_q == S_SQRT) ? 2'd0 : comp_q + 2'd1;
		iss_den = (state_q == S_SQRT) ? sq_root : root_q;
		if (job_q == J_RAD) begin
			iss_mag = (iss_idx == 2'd0) ? 24'(mu0_q[23] ? -mu0_q : mu0_q)
			                            : 24'(mu1_q[23] ? -mu1_q : mu1_q);
		end else begin
			iss_mag = 24'($unsigned(pick20(vec_q[0], vec_q[1], vec_q[2], iss_idx) < 0
				? -pick20(vec_q[0], vec_q[1], vec_q[2], iss_idx)
				: pick20(vec_q[0], vec_q[1], vec_q[2], iss_idx)));
		end
		iss_num = (zt_pkg::DIV_NW'(iss_mag) << F) + zt_pkg::DIV_NW'(iss_den >> 1);

		q_neg = pick20(vec_q[0], vec_q[1], vec_q[2], comp_q) < 0;
		if (q_neg) q_norm = (dv_quo > zt_pkg::DIV_NW'(1 << (FW - 1)))
			? {1'b1, {(FW-1){1'b0}}} : -$signed(dv_quo[FW-1:0]);
		else q_norm = (dv_quo > zt_pkg::DIV_NW'((1 << (FW - 1)) - 1))
			? {1'b0, {(FW-1){1'b1}}} : $signed(dv_quo[FW-1:0]);
		q_scale = (dv_quo > zt_pkg::DIV_NW'(zt_pkg::SCALE_SAT)) ? zt_pkg::SCALE_SAT
			: dv_quo[FW-1:0];
		max_upd = (q_scale > max_q) ? q_scale : max_q;
		acc_rnd = zt_pkg::shr_round(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			job_q      <= J_NC;
			term_q     <= '0;
			comp_q     <= '0;
			corner_q   <= '0;
			max_q      <= '0;
			m_tvalid_q <= 1'b0;
			sq_start_q <= 1'b0;
			dv_start_q <= 1'b0;
		end else begin
			sq_start_q <= 1'b0;
			dv_start_q <= 1'b0;
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0]) max_q <= '0;
						job_q   <= J_NC;
						term_q  <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (term_q == nterms) state_q <= S_POST;
					else term_q <= term_q + 2'd1;
				end
				S_POST: begin
					term_q <= '0;
					case (job_q)
						J_NC, J_NA: begin
							sq_start_q <= 1'b1;
							state_q    <= S_SQRT;
						end
						J_BX: begin
							state_q <= S_MAC;
							if (comp_q == 2'd2) begin
								comp_q   <= '0;
								corner_q <= '0;
								job_q    <= J_MU0;
							end else begin
								comp_q <= comp_q + 2'd1;
							end
						end
						J_MU0: begin
							job_q   <= J_MU1;
							state_q <= S_MAC;
						end
						J_MU1: begin
							job_q   <= J_RAD;
							state_q <= S_MAC;
						end
						default: begin
							if (acc_q <= 0) begin
								max_q <= zt_pkg::SCALE_SAT;
								if (corner_q == 2'd2) begin
									state_q <= S_DONE;
								end else begin
									corner_q <= corner_q + 2'd1;
									job_q    <= J_MU0;
									state_q  <= S_MAC;
								end
							end else begin
								sq_start_q <= 1'b1;
								state_q    <= S_SQRT;
							end
						end
					endcase
				end
				S_SQRT: begin
					if (sq_done) begin
						comp_q <= '0;
						if (sq_root == '0) begin
							term_q  <= '0;
							state_q <= S_MAC;
							if (job_q == J_NC) job_q <= J_NA;
							else begin
								job_q <= J_BX;
							end
						end else begin
							dv_start_q <= 1'b1;
							state_q    <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (dv_done) begin
						if (job_q == J_RAD) max_q <= max_upd;
						if ((job_q == J_RAD && comp_q == 2'd1) || comp_q == 2'd2) begin
							comp_q <= '0;
							term_q <= '0;
							case (job_q)
								J_NC: begin
									job_q   <= J_NA;
									state_q <= S_MAC;
								end
								J_NA: begin
									job_q   <= J_BX;
									state_q <= S_MAC;
								end
								default: begin
									if (corner_q == 2'd2) begin
										state_q <= S_DONE;
									end else begin
										corner_q <= corner_q + 2'd1;
										job_q    <= J_MU0;
										state_q  <= S_MAC;
									end
								end
							endcase
						end else begin
							comp_q     <= comp_q + 2'd1;
							dv_start_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					zone_q <= s_tdata[15:0];
					for (int k = 0; k < 9; k++) c_q[k] <= s_tdata[16 + FW*k +: FW];
					for (int i = 0; i < 3; i++) vec_q[i] <= 20'(s_tdata[16 + FW*i +: FW] + 0)
						+ 20'($signed(s_tdata[16 + FW*(i+3) +: FW]))
						+ 20'($signed(s_tdata[16 + FW*(i+6) +: FW]))
						- 20'(s_tdata[16 + FW*i +: FW] + 0)
						+ 20'($signed(s_tdata[16 + FW*i +: FW]));
					acc_q <= '0;
				end
			end
			S_MAC: begin
				if (term_q != 2'd0) acc_q <= acc_q + {{(AW-zt_pkg::PROD_W){prod_q[zt_pkg::PROD_W-1]}}, prod_q};
				prod_q <= mul_neg ? -mul_p : mul_p;
			end
			S_POST: begin
				acc_q <= '0;
				case (job_q)
					J_NC, J_NA: sq_val_q <= acc_q[zt_pkg::SQ_W-1:0];
					J_BX: begin
						case (comp_q)
							2'd0:    bx_q[0] <= zt_pkg::sat18(acc_rnd);
							2'd1:    bx_q[1] <= zt_pkg::sat18(acc_rnd);
							default: bx_q[2] <= zt_pkg::sat18(acc_rnd);
						endcase
					end
					J_MU0: mu0_q <= acc_rnd[23:0];
					J_MU1: begin
						mu1_q <= acc_rnd[23:0];
						acc_q <= AW'(1) <<< (2 * F);
					end
					default: sq_val_q <= acc_q[zt_pkg::SQ_W-1:0];
				endcase
				if (job_q == J_RAD && acc_q <= 0) acc_q <= '0;
			end
			S_SQRT: begin
				if (sq_done) begin
					root_q   <= sq_root;
					dv_num_q <= iss_num;
					dv_den_q <= iss_den;
					acc_q    <= '0;
					if (sq_root == '0) begin
						if (job_q == J_NC) begin
							for (int i = 0; i < 3; i++) begin
								ctr_q[i] <= '0;
								vec_q[i] <= '0;
							end
						end else if (job_q == J_NA) begin
							for (int i = 0; i < 3; i++) ax_q[i] <= '0;
							degen_q <= 1'b1;
						end
					end
				end
			end
			S_DIV: begin
				if (dv_done) begin
					dv_num_q <= iss_num;
					dv_den_q <= iss_den;
					acc_q    <= '0;
					if (job_q == J_NC) begin
						case (comp_q)
							2'd0:    ctr_q[0] <= q_norm;
							2'd1:    ctr_q[1] <= q_norm;
							default: begin
								ctr_q[2] <= q_norm;
								vec_q[0] <= -{{2{ctr_q[1][FW-1]}}, ctr_q[1]};
								vec_q[1] <= {{2{ctr_q[0][FW-1]}}, ctr_q[0]};
								vec_q[2] <= '0;
							end
						endcase
					end else if (job_q == J_NA) begin
						degen_q <= 1'b0;
						case (comp_q)
							2'd0:    ax_q[0] <= q_norm;
							2'd1:    ax_q[1] <= q_norm;
							default: ax_q[2] <= q_norm;
						endcase
					end
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_data_q <= {4'b0, max_q, bx_q[2], bx_q[1], bx_q[0], ax_q[2], ax_q[1],
						ax_q[0], ctr_q[2], ctr_q[1], ctr_q[0], zone_q};
					out_user_q <= degen_q;
				end
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_user_q;
endmodule

/* hw/rtl/zt_checker.sv */
// Port-level checker for the zone tangent frame block, with its bind.
`timescale 1ns / 1ps
module zt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [183:0] s_tdata,
	input logic [0:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [199:0] m_tdata,
	input logic [0:0]   m_tuser
);
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while item in work");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_degen_axes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[177:70] == '0)
		else $error("degenerate frame with nonzero axes");
endmodule

bind zone_tangent_frame zt_checker u_zt_checker (.*);
